/* hdl/cktd_pkg.sv */
// ----------------------------------------------------------------------------
// cktd_pkg
// Request codes, result codes and controller states for the counted key
// table with sorted dump.
// ----------------------------------------------------------------------------
package cktd_pkg;

	localparam int KEY_W = 32;
	localparam int CNT_W = 16;
	localparam int REQ_W = 2;
	localparam int STS_W = 3;

	localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SUB  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DUMP = 2'd2;

	typedef enum logic [STS_W-1:0] {
		STS_INSERTED    = 3'd0,
		STS_INCREMENTED = 3'd1,
		STS_DECREMENTED = 3'd2,
		STS_REMOVED     = 3'd3,
		STS_NOT_FOUND   = 3'd4,
		STS_TABLE_FULL  = 3'd5,
		STS_DUMP_ENTRY  = 3'd6,
		STS_DUMP_EMPTY  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_FINISH
	} state_t;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

/* hdl/counted_key_table_sorted_dump.sv */
// ----------------------------------------------------------------------------
// counted_key_table_sorted_dump
// Table of unique signed keys with saturating reference counts; add,
// subtract and a dump that streams live entries in ascending key order.
// ----------------------------------------------------------------------------
// Keys and counts sit in two single-port memories with a registered read; a
// scan reads one slot per cycle. An add or subtract request takes one full
// scan and gives one result. A dump runs one scan per live entry (a
// selection pass that finds the smallest key above the one sent before); an
// empty table answers with a single dump_empty result. A result held back
// by the receiver stalls the scan that follows it. The single memory read
// port sets the pace of these scans.
// A request type of 3 is taken and dropped. A finished result waits in the
// output register while the next request is taken.
module counted_key_table_sorted_dump #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cktd_pkg::KEY_W-1:0]        s_tdata,  // [31:0] key
	input  logic [cktd_pkg::REQ_W-1:0]        s_tuser,  // [1:0] req_type
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cktd_pkg::KEY_W+cktd_pkg::CNT_W-1:0] m_tdata, // [31:0] out_key, [47:32] out_count
	output logic [cktd_pkg::STS_W-1:0]        m_tuser,  // [2:0] status
	output logic                              m_tlast
);
	import cktd_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	// storage
	logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
	logic [CNT_W-1:0] cnt_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CW-1:0] live_q;

	// request
	logic [REQ_W-1:0] req_q;
	logic [KEY_W-1:0] key_q;

	// scan
	state_t state_q, state_d;
	logic [AW-1:0] rd_idx_q;
	logic          pend_s1;
	logic [AW-1:0] idx_s1;
	logic [KEY_W-1:0] key_rd_s1;
	logic [CNT_W-1:0] cnt_rd_s1;

	logic          hit_q;
	logic [AW-1:0] hit_idx_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic          free_found_q;
	logic [AW-1:0] free_idx_q;
	logic          best_found_q;
	logic [KEY_W-1:0] best_key_q;
	logic [CNT_W-1:0] best_cnt_q;
	logic          have_prev_q;
	logic [KEY_W-1:0] prev_key_q;
	logic [CW-1:0] emitted_q;

	// output register
	logic          out_valid_q;
	status_t       out_sts_q;
	logic [KEY_W-1:0] out_key_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic          out_last_q;

	// control
	logic issue, scan_init, accept, fire, out_free, dump_last;
	logic slot_live, above_prev, below_best;
	status_t       sts_d;
	logic [KEY_W-1:0] okey_d;
	logic [CNT_W-1:0] ocnt_d;
	logic          olast_d;
	logic          wr_key, wr_cnt, set_valid, clr_valid;
	logic [AW-1:0] wr_idx;
	logic [CNT_W-1:0] wr_cnt_val;

	assign out_free  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign dump_last = (emitted_q + CW'(1)) == live_q;

	assign slot_live  = valid_q[idx_s1];
	assign above_prev = !have_prev_q || ($signed(key_rd_s1) > $signed(prev_key_q));
	assign below_best = !best_found_q || ($signed(key_rd_s1) < $signed(best_key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		issue     = 1'b0;
		scan_init = 1'b0;
		fire      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser inside {REQ_ADD, REQ_SUB, REQ_DUMP})) begin
					scan_init = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (rd_idx_q == LAST_IDX) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					fire = 1'b1;
					if (req_q == REQ_DUMP && live_q != '0 && !dump_last) begin
						scan_init = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result and table update at the end of a scan
	always_comb begin
		sts_d      = STS_NOT_FOUND;
		okey_d     = key_q;
		ocnt_d     = '0;
		olast_d    = 1'b1;
		wr_key     = 1'b0;
		wr_cnt     = 1'b0;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		wr_idx     = hit_idx_q;
		wr_cnt_val = hit_cnt_q;
		case (req_q)
			REQ_ADD: begin
				if (hit_q) begin
					sts_d  = STS_INCREMENTED;
					wr_cnt = 1'b1;
					if (hit_cnt_q != CNT_MAX) begin
						wr_cnt_val = hit_cnt_q + CNT_W'(1);
					end
					ocnt_d = wr_cnt_val;
				end else if (free_found_q) begin
					sts_d      = STS_INSERTED;
					wr_idx     = free_idx_q;
					wr_key     = 1'b1;
					wr_cnt     = 1'b1;
					wr_cnt_val = CNT_W'(1);
					set_valid  = 1'b1;
					ocnt_d     = CNT_W'(1);
				end else begin
					sts_d = STS_TABLE_FULL;
				end
			end
			REQ_SUB: begin
				if (!hit_q) begin
					sts_d = STS_NOT_FOUND;
				end else if (hit_cnt_q <= CNT_W'(1)) begin
					sts_d     = STS_REMOVED;
					clr_valid = 1'b1;
				end else begin
					sts_d      = STS_DECREMENTED;
					wr_cnt     = 1'b1;
					wr_cnt_val = hit_cnt_q - CNT_W'(1);
					ocnt_d     = wr_cnt_val;
				end
			end
			REQ_DUMP: begin
				if (live_q == '0) begin
					sts_d  = STS_DUMP_EMPTY;
					okey_d = '0;
				end else begin
					sts_d   = STS_DUMP_ENTRY;
					okey_d  = best_key_q;
					ocnt_d  = best_cnt_q;
					olast_d = dump_last;
				end
			end
			default: begin
				sts_d = STS_NOT_FOUND;
			end
		endcase
	end

	// memories: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (fire && wr_key) begin
			key_mem[wr_idx] <= key_q;
		end
		key_rd_s1 <= key_mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (fire && wr_cnt) begin
			cnt_mem[wr_idx] <= wr_cnt_val;
		end
		cnt_rd_s1 <= cnt_mem[rd_idx_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			live_q       <= '0;
			rd_idx_q     <= '0;
			pend_s1      <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			have_prev_q  <= 1'b0;
			emitted_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
			if (accept) begin
				have_prev_q <= 1'b0;
				emitted_q   <= '0;
			end
			if (scan_init) begin
				rd_idx_q     <= '0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
				best_found_q <= 1'b0;
			end
			if (pend_s1) begin
				if (slot_live && key_rd_s1 == key_q) begin
					hit_q <= 1'b1;
				end
				if (!slot_live) begin
					free_found_q <= 1'b1;
				end
				if (slot_live && above_prev && below_best) begin
					best_found_q <= 1'b1;
				end
			end
			if (fire) begin
				if (set_valid) begin
					valid_q[wr_idx] <= 1'b1;
					live_q          <= live_q + CW'(1);
				end
				if (clr_valid) begin
					valid_q[hit_idx_q] <= 1'b0;
					live_q             <= live_q - CW'(1);
				end
				// advance the lower bound for the next selection pass
				have_prev_q <= 1'b1;
				emitted_q   <= emitted_q + CW'(1);
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= s_tuser;
			key_q <= s_tdata;
		end
		if (issue) begin
			idx_s1 <= rd_idx_q;
		end
		if (pend_s1) begin
			if (slot_live && key_rd_s1 == key_q) begin
				hit_idx_q <= idx_s1;
				hit_cnt_q <= cnt_rd_s1;
			end
			// keep the lowest free slot
			if (!slot_live && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (slot_live && above_prev && below_best) begin
				best_key_q <= key_rd_s1;
				best_cnt_q <= cnt_rd_s1;
			end
		end
		if (fire) begin
			prev_key_q <= best_key_q;
			out_sts_q  <= sts_d;
			out_key_q  <= okey_d;
			out_cnt_q  <= ocnt_d;
			out_last_q <= olast_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_cnt_q, out_key_q};
	assign m_tuser  = out_sts_q;
	assign m_tlast  = out_last_q;

endmodule
